// File: hdl/pct_pkg.sv
// shared types, constants and helpers for the polar/cartesian point tracker
// no dependencies
`default_nettype none
package pct_pkg;

    localparam int WIDTH     = 32;
    localparam int FRAC_BITS = 16;
    localparam int ANG_Q     = 30;
    localparam int ASH       = ANG_Q - FRAC_BITS;
    localparam int GUARD     = 8;
    localparam int ITERS     = 28;
    localparam int CW        = 44;   // cordic datapath width
    localparam int ZW        = 36;   // angle accumulator width
    localparam int AW        = 20;   // stored angle width
    localparam int MW        = 30;   // bits of the inverse gain

    typedef logic signed [WIDTH-1:0] coord_t;
    typedef logic signed [CW-1:0]    cw_t;
    typedef logic signed [ZW-1:0]    zw_t;
    typedef logic        [AW-1:0]    ang_t;

    localparam logic [MW-1:0] INV_GAIN = 30'd652032874;

    localparam zw_t PI_Q            = 36'sd3373259426;
    localparam zw_t HALF_PI_Q       = 36'sd1686629713;
    localparam zw_t THREE_HALF_PI_Q = 36'sd5059889139;
    localparam zw_t TWO_PI_Q        = 36'sd6746518852;

    localparam longint TWO_PI_L  = (64'd6746518852 + 64'd8192) / 64'd16384;
    localparam longint HALF_PI_L = (64'd1686629713 + 64'd8192) / 64'd16384;
    localparam longint PI_L      = (64'd3373259426 + 64'd8192) / 64'd16384;
    localparam longint THP_L     = (64'd5059889139 + 64'd8192) / 64'd16384;

    localparam ang_t TWO_PI_S      = AW'(TWO_PI_L);
    localparam ang_t HALF_PI_S     = AW'(HALF_PI_L);
    localparam ang_t PI_S          = AW'(PI_L);
    localparam ang_t THREE_HALF_PI_S = AW'(THP_L);

    // clamp to the signed coordinate range
    function automatic coord_t sat48(input logic signed [47:0] v);
        logic signed [47:0] hi;
        logic signed [47:0] lo;
        hi = 48'sd2147483647;
        lo = -48'sd2147483648;
        if (v > hi)
            sat48 = coord_t'(hi);
        else if (v < lo)
            sat48 = coord_t'(lo);
        else
            sat48 = coord_t'(v);
    endfunction

    function automatic zw_t atan_q30(input logic [4:0] i);
        case (i)
            5'd0:  atan_q30 = 36'sh03243F6A8;
            5'd1:  atan_q30 = 36'sh01DAC6705;
            5'd2:  atan_q30 = 36'sh00FADBAFC;
            5'd3:  atan_q30 = 36'sh007F56EA6;
            5'd4:  atan_q30 = 36'sh003FEAB76;
            5'd5:  atan_q30 = 36'sh001FFD55B;
            5'd6:  atan_q30 = 36'sh000FFFAAA;
            5'd7:  atan_q30 = 36'sh0007FFF55;
            5'd8:  atan_q30 = 36'sh0003FFFEA;
            5'd9:  atan_q30 = 36'sh0001FFFFD;
            5'd10: atan_q30 = 36'sh0000FFFFF;
            5'd11: atan_q30 = 36'sh00007FFFF;
            5'd12: atan_q30 = 36'sh00003FFFF;
            5'd13: atan_q30 = 36'sh00001FFFF;
            5'd14: atan_q30 = 36'sh00000FFFF;
            5'd15: atan_q30 = 36'sh000007FFF;
            5'd16: atan_q30 = 36'sh000003FFF;
            5'd17: atan_q30 = 36'sh000001FFF;
            5'd18: atan_q30 = 36'sh000000FFF;
            5'd19: atan_q30 = 36'sh0000007FF;
            5'd20: atan_q30 = 36'sh0000003FF;
            5'd21: atan_q30 = 36'sh0000001FF;
            5'd22: atan_q30 = 36'sh0000000FF;
            5'd23: atan_q30 = 36'sh00000007F;
            5'd24: atan_q30 = 36'sh00000003F;
            5'd25: atan_q30 = 36'sh00000001F;
            5'd26: atan_q30 = 36'sh00000000F;
            5'd27: atan_q30 = 36'sh000000008;
            default: atan_q30 = '0;
        endcase
    endfunction

endpackage
`default_nettype wire

// File: hdl/pct_gain_mul.sv
// bit-serial multiply of two lanes by the inverse cordic gain, then rescale and saturate
// depends on pct_pkg
`default_nettype none
module pct_gain_mul (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire pct_pkg::cw_t    va,
    input  wire pct_pkg::cw_t    vb,
    output logic                 done,
    output pct_pkg::coord_t      ra,
    output pct_pkg::coord_t      rb
);
    import pct_pkg::*;

    logic [CW:0]   acc_a_reg, acc_a_next, acc_b_reg, acc_b_next;
    logic [CW-1:0] mag_a_reg, mag_a_next, mag_b_reg, mag_b_next;
    logic          neg_a_reg, neg_a_next, neg_b_reg, neg_b_next;
    logic          rnd_a_reg, rnd_a_next, rnd_b_reg, rnd_b_next;
    logic [4:0]    cnt_reg, cnt_next;
    logic          busy_reg, busy_next, done_reg, done_next;
    logic [CW:0]   sum_a, sum_b;

    function automatic coord_t finish(input logic [CW:0] acc, input logic rnd,
                                      input logic neg);
        logic signed [CW+1:0] r;
        logic signed [CW+1:0] s;
        logic signed [CW+1:0] t;
        r = $signed({1'b0, acc}) + $signed({{(CW+1){1'b0}}, rnd});
        s = neg ? -r : r;
        t = (s + 46'sd128) >>> GUARD;
        finish = sat48(48'(t));
    endfunction

    always_comb
    begin
        sum_a = acc_a_reg + (INV_GAIN[cnt_reg] ? {1'b0, mag_a_reg} : '0);
        sum_b = acc_b_reg + (INV_GAIN[cnt_reg] ? {1'b0, mag_b_reg} : '0);
        acc_a_next = acc_a_reg;
        acc_b_next = acc_b_reg;
        mag_a_next = mag_a_reg;
        mag_b_next = mag_b_reg;
        neg_a_next = neg_a_reg;
        neg_b_next = neg_b_reg;
        rnd_a_next = rnd_a_reg;
        rnd_b_next = rnd_b_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            neg_a_next = va[CW-1];
            neg_b_next = vb[CW-1];
            mag_a_next = va[CW-1] ? CW'(-va) : CW'(va);
            mag_b_next = vb[CW-1] ? CW'(-vb) : CW'(vb);
            acc_a_next = '0;
            acc_b_next = '0;
            cnt_next   = '0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_a_next = sum_a >> 1;
            acc_b_next = sum_b >> 1;
            cnt_next   = cnt_reg + 5'd1;
            // last dropped bit is the rounding bit
            if (cnt_reg == 5'(MW - 1))
            begin
                rnd_a_next = sum_a[0];
                rnd_b_next = sum_b[0];
                busy_next  = 1'b0;
                done_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_a_reg <= '0;
            acc_b_reg <= '0;
            mag_a_reg <= '0;
            mag_b_reg <= '0;
            neg_a_reg <= 1'b0;
            neg_b_reg <= 1'b0;
            rnd_a_reg <= 1'b0;
            rnd_b_reg <= 1'b0;
            cnt_reg   <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            acc_a_reg <= acc_a_next;
            acc_b_reg <= acc_b_next;
            mag_a_reg <= mag_a_next;
            mag_b_reg <= mag_b_next;
            neg_a_reg <= neg_a_next;
            neg_b_reg <= neg_b_next;
            rnd_a_reg <= rnd_a_next;
            rnd_b_reg <= rnd_b_next;
            cnt_reg   <= cnt_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign done = done_reg;
    assign ra   = finish(acc_a_reg, rnd_a_reg, neg_a_reg);
    assign rb   = finish(acc_b_reg, rnd_b_reg, neg_b_reg);

endmodule
`default_nettype wire

// File: hdl/polar_cartesian_point_tracker.sv
// top level of the polar/cartesian point tracker: control, angle wrap and cordic
// depends on pct_pkg and pct_gain_mul
//
// usage:
//   input channel (in_valid/in_ready, op, amount) moves one coordinate:
//   op 0 x, op 1 y, op 2 radius, op 3 angle; amount is signed q16.16
//   output channel (out_valid/out_ready, x_pos, y_pos) gives one transfer
//   per input transfer with the new point, q16.16, saturated
// timing:
//   one item at a time; in_ready is high only while the engine is idle
//   x or y move: a setup step, 28 cordic iterations, then the gain multiply
//   radius move: same; angle move first runs a bit-serial modulo 2pi
//   an x or y move that lands on an axis or the origin skips cordic and multiply
//   the result is then loaded into the output register
// stalls:
//   the output register holds its transfer while out_ready is low; the next
//   item may still be taken and computed, and waits to load the output
// reset:
//   rst_n clears the point to the origin and empties the output register
`default_nettype none
module polar_cartesian_point_tracker (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [1:0]       op,
    input  wire pct_pkg::coord_t  amount,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output pct_pkg::coord_t       x_pos,
    output pct_pkg::coord_t       y_pos
);
    import pct_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MOD  = 3'd1;
    localparam logic [2:0] S_VEC  = 3'd2;
    localparam logic [2:0] S_ROT  = 3'd3;
    localparam logic [2:0] S_CORD = 3'd4;
    localparam logic [2:0] S_MUL  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    localparam logic [1:0] OP_X   = 2'd0;
    localparam logic [1:0] OP_Y   = 2'd1;
    localparam logic [1:0] OP_RAD = 2'd2;
    localparam logic [1:0] OP_ANG = 2'd3;

    localparam int MODW = 33;

    // multiple of 2pi that lifts any angle sum to a nonnegative value
    localparam logic [MODW-1:0] MOD_BIAS = MODW'(longint'(TWO_PI_L) * 64'd8192);

    logic [2:0]      state_reg, state_next;
    coord_t          x_reg, x_next, y_reg, y_next, rad_reg, rad_next;
    ang_t            ang_reg, ang_next;
    cw_t             cx_reg, cx_next, cy_reg, cy_next;
    zw_t             z_reg, z_next;
    logic [4:0]      iter_reg, iter_next;
    logic            vec_reg, vec_next;
    logic [MODW-1:0] modv_reg, modv_next;
    logic [AW-1:0]   modr_reg, modr_next;
    logic [5:0]      cnt_reg, cnt_next;
    logic            ov_reg, ov_next;
    coord_t          xo_reg, xo_next, yo_reg, yo_next;

    logic            mul_start;
    cw_t             mul_va, mul_vb;
    logic            mul_done;
    coord_t          mul_ra, mul_rb;

    logic signed [33:0] ang_sum;
    logic [AW:0]        mod_try;
    cw_t                sh_x, sh_y;
    zw_t                at, zr, zfix;
    logic signed [ZW-1:0] ang_round;
    ang_t               ang_new;
    cw_t                rr;

    pct_gain_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .va    (mul_va),
        .vb    (mul_vb),
        .done  (mul_done),
        .ra    (mul_ra),
        .rb    (mul_rb)
    );

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        rad_next   = rad_reg;
        ang_next   = ang_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        z_next     = z_reg;
        iter_next  = iter_reg;
        vec_next   = vec_reg;
        modv_next  = modv_reg;
        modr_next  = modr_reg;
        cnt_next   = cnt_reg;
        xo_next    = xo_reg;
        yo_next    = yo_reg;
        ov_next    = ov_reg && !out_ready;
        mul_start  = 1'b0;
        mul_va     = cx_reg;
        mul_vb     = cy_reg;

        ang_sum = $signed({14'd0, ang_reg}) + 34'(amount);
        mod_try = {modr_reg, modv_reg[MODW-1]};
        sh_x    = cx_reg >>> iter_reg;
        sh_y    = cy_reg >>> iter_reg;
        at      = atan_q30(iter_reg);
        zr      = $signed({{(ZW-AW-ASH){1'b0}}, ang_reg, {ASH{1'b0}}});
        zfix    = (z_reg < 0) ? z_reg + TWO_PI_Q : z_reg;
        // round the q30 angle to the stored format, wrapping 2pi to zero
        ang_round = (zfix + zw_t'(1 << (ASH - 1))) >>> ASH;
        ang_new   = AW'(ang_round);
        if (ang_new >= TWO_PI_S)
            ang_new = ang_new - TWO_PI_S;
        rr = cw_t'(rad_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (op)
                        OP_X:
                        begin
                            x_next     = sat48(48'(x_reg) + 48'(amount));
                            state_next = S_VEC;
                        end
                        OP_Y:
                        begin
                            y_next     = sat48(48'(y_reg) + 48'(amount));
                            state_next = S_VEC;
                        end
                        OP_RAD:
                        begin
                            rad_next   = sat48(48'(rad_reg) + 48'(amount));
                            state_next = S_ROT;
                        end
                        OP_ANG:
                        begin
                            modv_next  = MODW'(ang_sum) + MOD_BIAS;
                            modr_next  = '0;
                            cnt_next   = '0;
                            state_next = S_MOD;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_MOD:
            begin
                // restoring remainder, one bit per cycle
                modv_next = modv_reg << 1;
                if (mod_try >= {1'b0, TWO_PI_S})
                    modr_next = AW'(mod_try - {1'b0, TWO_PI_S});
                else
                    modr_next = AW'(mod_try);
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(MODW - 1))
                begin
                    ang_next   = (mod_try >= {1'b0, TWO_PI_S}) ?
                                 AW'(mod_try - {1'b0, TWO_PI_S}) : AW'(mod_try);
                    state_next = S_ROT;
                end
            end
            S_VEC:
            begin
                vec_next  = 1'b1;
                iter_next = '0;
                if (x_reg == 0 && y_reg == 0)
                begin
                    rad_next   = '0;
                    ang_next   = '0;
                    state_next = S_OUT;
                end
                else if (x_reg == 0)
                begin
                    rad_next   = sat48(y_reg < 0 ? -48'(y_reg) : 48'(y_reg));
                    ang_next   = (y_reg > 0) ? HALF_PI_S : THREE_HALF_PI_S;
                    state_next = S_OUT;
                end
                else if (y_reg == 0)
                begin
                    rad_next   = sat48(x_reg < 0 ? -48'(x_reg) : 48'(x_reg));
                    ang_next   = (x_reg > 0) ? '0 : PI_S;
                    state_next = S_OUT;
                end
                else
                begin
                    cx_next    = (x_reg < 0 ? -cw_t'(x_reg) : cw_t'(x_reg)) <<< GUARD;
                    cy_next    = (x_reg < 0 ? -cw_t'(y_reg) : cw_t'(y_reg)) <<< GUARD;
                    z_next     = (x_reg < 0) ? PI_Q : '0;
                    state_next = S_CORD;
                end
            end
            S_ROT:
            begin
                vec_next  = 1'b0;
                iter_next = '0;
                cy_next   = '0;
                // fold the angle into the right half plane
                if (zr >= HALF_PI_Q && zr < THREE_HALF_PI_Q)
                begin
                    z_next  = zr - PI_Q;
                    cx_next = (-rr) <<< GUARD;
                end
                else if (zr >= THREE_HALF_PI_Q)
                begin
                    z_next  = zr - TWO_PI_Q;
                    cx_next = rr <<< GUARD;
                end
                else
                begin
                    z_next  = zr;
                    cx_next = rr <<< GUARD;
                end
                state_next = S_CORD;
            end
            S_CORD:
            begin
                // vectoring drives y to zero, rotation drives z to zero
                if (vec_reg ? (cy_reg >= 0) : (z_reg >= 0))
                begin
                    cx_next = vec_reg ? cx_reg + sh_y : cx_reg - sh_y;
                    cy_next = vec_reg ? cy_reg - sh_x : cy_reg + sh_x;
                    z_next  = vec_reg ? z_reg + at : z_reg - at;
                end
                else
                begin
                    cx_next = vec_reg ? cx_reg - sh_y : cx_reg + sh_y;
                    cy_next = vec_reg ? cy_reg + sh_x : cy_reg - sh_x;
                    z_next  = vec_reg ? z_reg - at : z_reg + at;
                end
                iter_next = iter_reg + 5'd1;
                if (iter_reg == 5'(ITERS - 1))
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                if (cnt_reg == '0)
                begin
                    mul_start = 1'b1;
                    cnt_next  = 6'd1;
                end
                else if (mul_done)
                begin
                    cnt_next = '0;
                    if (vec_reg)
                    begin
                        rad_next = mul_ra;
                        ang_next = ang_new;
                    end
                    else
                    begin
                        x_next = mul_ra;
                        y_next = mul_rb;
                    end
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // load once the output slot is free
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    xo_next    = x_reg;
                    yo_next    = y_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // multiply start needs a clear count on entry
        if (state_reg == S_CORD && iter_reg == 5'(ITERS - 1))
            cnt_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            x_reg     <= '0;
            y_reg     <= '0;
            rad_reg   <= '0;
            ang_reg   <= '0;
            cx_reg    <= '0;
            cy_reg    <= '0;
            z_reg     <= '0;
            iter_reg  <= '0;
            vec_reg   <= 1'b0;
            modv_reg  <= '0;
            modr_reg  <= '0;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
            xo_reg    <= '0;
            yo_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            rad_reg   <= rad_next;
            ang_reg   <= ang_next;
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
            z_reg     <= z_next;
            iter_reg  <= iter_next;
            vec_reg   <= vec_next;
            modv_reg  <= modv_next;
            modr_reg  <= modr_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
            xo_reg    <= xo_next;
            yo_reg    <= yo_next;
        end
    end

    assign out_valid = ov_reg;
    assign x_pos     = xo_reg;
    assign y_pos     = yo_reg;

endmodule
`default_nettype wire

// File: bench/tb_top.sv
// testbench for the polar/cartesian point tracker: random and directed moves,
// checked against a fixed-point cordic predictor; depends on pct_pkg and the rtl
`default_nettype none

// scoreboard: predicts the point after each move and checks output transfers
class point_scoreboard;
    longint x_now, y_now, r_now, a_now;
    longint exp_x[$];
    longint exp_y[$];
    int errors;

    function new();
        x_now = 0; y_now = 0; r_now = 0; a_now = 0; errors = 0;
    endfunction

    static function longint asr(longint v, int s);
        return v >>> s;
    endfunction

    static function longint rshr(longint v, int s);
        if (s == 0)
            return v;
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    static function longint clamp(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    static function longint gain_fix(longint v);
        bit neg;
        longint unsigned m, hi, lo, r;
        neg = v < 0;
        m = neg ? -v : v;
        hi = m >> 30;
        lo = m & ((64'd1 << 30) - 1);
        r = hi * 64'd652032874 + ((lo * 64'd652032874 + (64'd1 << 29)) >> 30);
        return neg ? -longint'(r) : longint'(r);
    endfunction

    static function longint atan_tab(int i);
        return longint'(pct_pkg::atan_q30(5'(i)));
    endfunction

    static function longint two_pi_s();
        return (64'sd6746518852 + 64'sd8192) / 64'sd16384;
    endfunction

    static function longint fold_angle(longint q30);
        longint a;
        a = rshr(q30, 14);
        if (a >= two_pi_s())
            a -= two_pi_s();
        return a;
    endfunction

    function void to_polar();
        longint cx, cy, z, t;
        if (x_now == 0 && y_now == 0)
        begin
            r_now = 0; a_now = 0;
            return;
        end
        if (x_now == 0)
        begin
            r_now = clamp(y_now < 0 ? -y_now : y_now);
            a_now = fold_angle(y_now > 0 ? 64'sd1686629713 : 64'sd5059889139);
            return;
        end
        if (y_now == 0)
        begin
            r_now = clamp(x_now < 0 ? -x_now : x_now);
            a_now = fold_angle(x_now > 0 ? 64'sd0 : 64'sd3373259426);
            return;
        end
        cx = (x_now < 0 ? -x_now : x_now) * 256;
        cy = (x_now < 0 ? -y_now : y_now) * 256;
        z = x_now < 0 ? 64'sd3373259426 : 64'sd0;
        for (int i = 0; i < 28; i++)
        begin
            t = cx;
            if (cy >= 0)
            begin
                cx = cx + asr(cy, i); cy = cy - asr(t, i); z += atan_tab(i);
            end
            else
            begin
                cx = cx - asr(cy, i); cy = cy + asr(t, i); z -= atan_tab(i);
            end
        end
        if (z < 0)
            z += 64'sd6746518852;
        r_now = clamp(rshr(gain_fix(cx), 8));
        a_now = fold_angle(z);
    endfunction

    function void to_cartesian();
        longint z, rr, cx, cy, t;
        z = a_now * 16384;
        rr = r_now;
        if (z >= 64'sd1686629713 && z < 64'sd5059889139)
        begin
            z -= 64'sd3373259426; rr = -rr;
        end
        else if (z >= 64'sd5059889139)
            z -= 64'sd6746518852;
        cx = rr * 256;
        cy = 0;
        for (int i = 0; i < 28; i++)
        begin
            t = cx;
            if (z >= 0)
            begin
                cx = cx - asr(cy, i); cy = cy + asr(t, i); z -= atan_tab(i);
            end
            else
            begin
                cx = cx + asr(cy, i); cy = cy - asr(t, i); z += atan_tab(i);
            end
        end
        x_now = clamp(rshr(gain_fix(cx), 8));
        y_now = clamp(rshr(gain_fix(cy), 8));
    endfunction

    // note an accepted move and queue the point it should produce
    function void note_move(logic [1:0] op, logic signed [31:0] amount);
        longint amt;
        amt = amount;
        case (op)
            2'd0: begin x_now = clamp(x_now + amt); to_polar(); end
            2'd1: begin y_now = clamp(y_now + amt); to_polar(); end
            2'd2: begin r_now = clamp(r_now + amt); to_cartesian(); end
            default:
            begin
                a_now = (a_now + amt) % two_pi_s();
                if (a_now < 0)
                    a_now += two_pi_s();
                to_cartesian();
            end
        endcase
        exp_x.push_back(x_now);
        exp_y.push_back(y_now);
    endfunction

    function void check_point(logic signed [31:0] xp, logic signed [31:0] yp);
        longint ex, ey;
        if (exp_x.size() == 0)
        begin
            $error("x_pos: expected nothing, actual %0d", xp);
            errors++;
            return;
        end
        ex = exp_x.pop_front();
        ey = exp_y.pop_front();
        if (longint'(xp) != ex)
        begin
            $error("x_pos: expected %0d, actual %0d", ex, xp);
            errors++;
        end
        if (longint'(yp) != ey)
        begin
            $error("y_pos: expected %0d, actual %0d", ey, yp);
            errors++;
        end
    endfunction
endclass

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_MOVES   = 1630;

    // opcodes of the move field
    localparam logic [1:0] MOVE_X      = 2'd0;
    localparam logic [1:0] MOVE_Y      = 2'd1;
    localparam logic [1:0] MOVE_RADIUS = 2'd2;
    localparam logic [1:0] MOVE_ANGLE  = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] op = '0;
    pct_pkg::coord_t amount = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    pct_pkg::coord_t x_pos;
    pct_pkg::coord_t y_pos;

    point_scoreboard board = new();
    bit stim_done = 1'b0;
    bit long_hold = 1'b0;   // request for a long receiver hold-off
    int idle_cycles = 0;

    polar_cartesian_point_tracker dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .op(op), .amount(amount),
        .out_valid(out_valid), .out_ready(out_ready),
        .x_pos(x_pos), .y_pos(y_pos)
    );

    always #10 clk = ~clk;

    // offer one move and wait for its transfer, with an optional random lead-in gap;
    // valid stays high after the transfer so back-to-back moves need no toggle
    task automatic send_move(logic [1:0] mop, logic [31:0] amt, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 11) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= mop;
        amount <= amt;
        do @(posedge clk); while (!in_ready);
        board.note_move(mop, amt);
    endtask

    // random amount: mostly moderate magnitudes, sometimes full range
    function automatic logic [31:0] pick_amount();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            2: return 32'($signed($urandom_range(0, 600000)) - 300000);
            3: return 32'($signed($urandom_range(0, 64)) - 32);
            default: return 32'($signed($urandom_range(0, 200000000)) - 100000000);
        endcase
    endfunction

    // the sender waits until every expected point has come back
    task automatic drain_wait();
        in_valid <= 1'b0;
        while (board.exp_x.size() != 0)
            @(posedge clk);
    endtask

    // sender
    initial
    begin
        logic [31:0] dir_amt[$];
        logic [1:0]  dir_op[$];
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: origin, axes, extremes, saturation, wrap, negative radius
        dir_op = '{MOVE_X, MOVE_X, MOVE_Y, MOVE_Y, MOVE_Y, MOVE_X, MOVE_X, MOVE_X,
                   MOVE_Y, MOVE_Y, MOVE_RADIUS, MOVE_RADIUS, MOVE_RADIUS,
                   MOVE_ANGLE, MOVE_ANGLE, MOVE_ANGLE, MOVE_ANGLE, MOVE_ANGLE,
                   MOVE_RADIUS, MOVE_ANGLE, MOVE_X, MOVE_Y, MOVE_ANGLE, MOVE_RADIUS};
        dir_amt = '{32'sd0, 32'sd65536, 32'sd65536, -32'sd65536, -32'sd65536,
                    -32'sd65536, -32'sd65536, 32'h7fffffff, 32'h7fffffff,
                    32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000,
                    32'sd102944, 32'sd411775, -32'sd102944, 32'h7fffffff,
                    32'h80000000, 32'sd3000000, 32'sd205887, 32'sd12345,
                    -32'sd54321, 32'sd1, -32'sd9000000};
        foreach (dir_op[i])
            send_move(dir_op[i], dir_amt[i], 1'b0);

        for (int n = 0; n < RANDOM_MOVES; n++)
        begin
            if (n == 300)
                long_hold = 1'b1;
            if (n == 800)
                drain_wait();
            send_move(2'($urandom_range(0, 3)), pick_amount(), $urandom_range(0, 3) != 0);
        end
        in_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // receiver: random stalls, plus one long hold-off so the input backs up
    initial
    begin
        int stall;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold)
            begin
                long_hold = 1'b0;
                out_ready <= 1'b0;
                repeat (600) @(posedge clk);
            end
            stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // output monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                board.check_point(x_pos, y_pos);
            if ((out_valid && out_ready) || (in_valid && in_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // end of run
    initial
    begin
        @(posedge rst_n);
        fork
            begin
                wait (stim_done);
                while (board.exp_x.size() != 0)
                    @(posedge clk);
                repeat (200) @(posedge clk);
            end
            begin
                wait (idle_cycles >= WATCHDOG_LIMIT);
                board.errors++;
                $display("watchdog expired, pending points %0d", board.exp_x.size());
            end
        join_any
        if (board.errors == 0 && board.exp_x.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire

// File: sim.f
hdl/pct_pkg.sv
hdl/pct_gain_mul.sv
hdl/polar_cartesian_point_tracker.sv
bench/tb_top.sv
